@@ rtl/cic_pkg.sv @@
// Package for the compact integer codec: operation codes, wire markers,
// stream widths and the single-pass encode functions.
// No dependencies.
package cic_pkg;

  // operation codes carried in s_axis_tuser
  localparam logic [1:0] OP_ENC_S = 2'd0;
  localparam logic [1:0] OP_ENC_U = 2'd1;
  localparam logic [1:0] OP_DEC_S = 2'd2;
  localparam logic [1:0] OP_DEC_U = 2'd3;

  // signed-format markers
  localparam logic [7:0] MARK_SHORT = 8'h80;
  localparam logic [7:0] MARK_LONG  = 8'h81;

  localparam int OP_W      = 2;
  localparam int VAL_W     = 32;
  localparam int BYTE_W    = 8;
  localparam int MAX_BYTES = 5;
  localparam int S_DATA_W  = 40;   // value, in_byte
  localparam int M_DATA_W  = 40;   // out_byte, decoded_value
  localparam int BUF_W     = MAX_BYTES * BYTE_W;

  // encoded bytes, first byte in the lowest bits, and their count
  typedef struct packed {
    logic [BUF_W-1:0] bytes;
    logic [2:0]       cnt;
  } enc_t;

  function automatic enc_t enc_signed(input logic [VAL_W-1:0] n);
    enc_t r;
    logic [VAL_W-1:0] off_s;
    logic [VAL_W-1:0] off_m;
    off_s = n + 32'd126;
    off_m = n + 32'h0000_8000;
    r.bytes = '0;
    if (off_s <= 32'd253) begin
      r.bytes[7:0] = n[7:0];
      r.cnt = 3'd1;
    end else if (off_m <= 32'h0000_FFFF) begin
      r.bytes[23:0] = {n[15:8], n[7:0], MARK_SHORT};
      r.cnt = 3'd3;
    end else begin
      r.bytes = {n, MARK_LONG};
      r.cnt = 3'd5;
    end
    return r;
  endfunction

  function automatic enc_t enc_unsigned(input logic [VAL_W-1:0] n);
    enc_t r;
    r.bytes = '0;
    if (|n[31:21]) begin
      r.bytes[31:0] = {n[28:21], 1'b1, n[20:14], 1'b1, n[13:7], 1'b1, n[6:0]};
      r.cnt = 3'd4;
    end else if (n[20:7] == 14'd0) begin
      r.bytes[7:0] = n[7:0];
      r.cnt = 3'd1;
    end else if (n[20:14] == 7'd0) begin
      r.bytes[15:0] = {n[14:7], 1'b1, n[6:0]};
      r.cnt = 3'd2;
    end else begin
      r.bytes[23:0] = {n[21:14], 1'b1, n[13:7], 1'b1, n[6:0]};
      r.cnt = 3'd3;
    end
    return r;
  endfunction

endpackage

@@ rtl/compact_integer_codec_unit.sv @@
// Compact integer codec, top level: input register, single-pass encode and
// decode logic, result register feeding the output stream.
// Depends on cic_pkg.
//
// Flow: an accepted item waits in the input register, moves into the result
//   register once that is free, and its output beats are sent from there.
// Throughput: one input item per cycle while the output keeps up. Decode items
//   produce at most one beat; an encode item holds the output until all its
//   bytes (1 to 5) are sent, one beat per cycle while m_axis_tready is high.
// Reset (rst, synchronous, active high) empties both registers and clears the
//   decode state; no clearing pass is needed.
module compact_integer_codec_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cic_pkg::S_DATA_W-1:0]  s_axis_tdata,  // value[31:0], in_byte[39:32]
  input  logic [cic_pkg::OP_W-1:0]      s_axis_tuser,  // operation[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cic_pkg::M_DATA_W-1:0]  m_axis_tdata,  // out_byte[7:0], decoded_value[39:8]
  output logic                          m_axis_tlast,  // last_byte
  output logic                          m_axis_tuser   // value_ready
);
  import cic_pkg::*;

  // input register
  logic                in_valid;
  logic [OP_W-1:0]     in_op;
  logic [VAL_W-1:0]    in_val;
  logic [BYTE_W-1:0]   in_byte;

  // result register: bytes still to send (encode) or the decoded value
  logic [BUF_W-1:0]    r_data;
  logic [2:0]          r_cnt;
  logic                r_dec;

  // decode state
  logic                fmt;
  logic [2:0]          pend;
  logic [2:0]          idx;
  logic [VAL_W-1:0]    acc;
  logic                fmt_next;
  logic [2:0]          pend_next;
  logic [2:0]          idx_next;
  logic [VAL_W-1:0]    acc_next;

  logic                fmt_eff;
  logic                is_dec;
  logic                dec_emit;
  logic [VAL_W-1:0]    dec_val;
  logic [VAL_W-1:0]    acc_tmp;
  logic [VAL_W-1:0]    sh;
  enc_t                enc;

  logic                s_acc;
  logic                m_beat;
  logic                final_beat;
  logic                r_free;
  logic                move;

  assign m_axis_tvalid = (r_cnt != 3'd0);
  assign m_beat        = m_axis_tvalid && m_axis_tready;
  assign final_beat    = m_beat && (r_cnt == 3'd1);
  // result register free now, or its last beat leaves this cycle
  assign r_free        = (r_cnt == 3'd0) || final_beat;
  assign move          = in_valid && r_free;
  // input register takes a new beat when empty or while the held one moves on
  assign s_axis_tready = !in_valid || move;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign m_axis_tdata  = r_dec ? {r_data[VAL_W-1:0], 8'h00}
                               : {{VAL_W{1'b0}}, r_data[BYTE_W-1:0]};
  assign m_axis_tlast  = !r_dec && (r_cnt == 3'd1);
  assign m_axis_tuser  = r_dec;

  assign is_dec = (in_op == OP_DEC_S) || (in_op == OP_DEC_U);

  always_comb begin
    enc = (in_op == OP_ENC_S) ? enc_signed(in_val) : enc_unsigned(in_val);
  end

  // decode step; the operation picks the format only on a value's first byte
  always_comb begin
    fmt_eff   = (pend == 3'd0) ? (in_op == OP_DEC_U) : fmt;
    fmt_next  = fmt;
    pend_next = pend;
    idx_next  = idx;
    acc_next  = acc;
    dec_emit  = 1'b0;
    dec_val   = '0;
    acc_tmp   = acc;
    sh        = '0;
    if (is_dec) begin
      fmt_next = fmt_eff;
      if (!fmt_eff) begin
        if (pend == 3'd0) begin
          if (in_byte == MARK_SHORT) begin
            pend_next = 3'd2;
            idx_next  = 3'd0;
            acc_next  = '0;
          end else if (in_byte == MARK_LONG) begin
            pend_next = 3'd4;
            idx_next  = 3'd0;
            acc_next  = '0;
          end else begin
            dec_emit = 1'b1;
            dec_val  = {{(VAL_W-BYTE_W){in_byte[7]}}, in_byte};
          end
        end else begin
          sh        = {24'd0, in_byte} << {idx[1:0], 3'b000};
          acc_tmp   = acc | sh;
          idx_next  = idx + 3'd1;
          pend_next = pend - 3'd1;
          acc_next  = acc_tmp;
          if (pend_next == 3'd0) begin
            // short form: sign-extend from bit 15
            if (idx_next == 3'd2 && acc_tmp[15]) begin
              acc_tmp[31:16] = 16'hFFFF;
            end
            dec_emit = 1'b1;
            dec_val  = acc_tmp;
          end
        end
      end else begin
        if (pend == 3'd0) begin
          if (!in_byte[7]) begin
            dec_emit = 1'b1;
            dec_val  = {24'd0, in_byte};
          end else begin
            acc_next  = {25'd0, in_byte[6:0]};
            idx_next  = 3'd1;
            pend_next = 3'd1;
          end
        end else if (idx >= 3'd3) begin
          // fourth byte always ends; sign-extend from bit 28
          acc_tmp  = acc | {3'd0, in_byte, 21'd0};
          if (acc_tmp[28]) begin
            acc_tmp[31:29] = 3'b111;
          end
          dec_emit = 1'b1;
          dec_val  = acc_tmp;
        end else begin
          case (idx[1:0])
            2'd1:    sh = {18'd0, in_byte[6:0], 7'd0};
            2'd2:    sh = {11'd0, in_byte[6:0], 14'd0};
            default: sh = {25'd0, in_byte[6:0]};
          endcase
          acc_tmp  = acc | sh;
          acc_next = acc_tmp;
          if (!in_byte[7]) begin
            dec_emit = 1'b1;
            dec_val  = acc_tmp;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      if (dec_emit) begin
        pend_next = '0;
        idx_next  = '0;
        acc_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_acc) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_val  <= s_axis_tdata[VAL_W-1:0];
      in_byte <= s_axis_tdata[VAL_W+BYTE_W-1:VAL_W];
      in_op   <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt <= '0;
      r_dec <= 1'b0;
    end else if (move) begin
      r_dec <= is_dec;
      if (is_dec) begin
        r_cnt <= dec_emit ? 3'd1 : 3'd0;
      end else begin
        r_cnt <= enc.cnt;
      end
    end else if (m_beat) begin
      r_cnt <= r_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      r_data <= is_dec ? {8'd0, dec_val} : enc.bytes;
    end else if (m_beat) begin
      r_data <= {8'd0, r_data[BUF_W-1:BYTE_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt  <= 1'b0;
      pend <= '0;
      idx  <= '0;
      acc  <= '0;
    end else if (move && is_dec) begin
      fmt  <= fmt_next;
      pend <= pend_next;
      idx  <= idx_next;
      acc  <= acc_next;
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    r_cnt <= 3'd5)
    else $error("result count out of range");

  a_dec_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && r_dec |-> r_cnt == 3'd1 && !m_axis_tlast)
    else $error("decode result spans more than one beat");

  a_enc_continues: assert property (@(posedge clk) disable iff (rst)
    m_beat && !m_axis_tlast && !r_dec |=> m_axis_tvalid && !r_dec)
    else $error("encoded value cut short");

  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pend <= 3'd4)
    else $error("pending byte count out of range");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    move && is_dec && dec_emit |=> pend == 3'd0 && idx == 3'd0)
    else $error("decode state not cleared after a value");

endmodule

@@ tb/compact_integer_codec_unit_tb.sv @@
// Testbench for compact_integer_codec_unit: drives encode and decode items on the
// input stream and checks every output beat against a behavioural predictor.
// Depends on cic_pkg and the RTL of compact_integer_codec_unit.
`timescale 1ns / 100ps

module compact_integer_codec_unit_tb;
  import cic_pkg::*;

  // one output beat as the predictor sees it
  typedef struct packed {
    logic [7:0]  wire_byte;
    logic        last;
    logic [31:0] value;
    logic        ready;
  } codec_beat_t;

  // Scoreboard: carries its own copy of the decode state and the queue of
  // beats still owed by the block, oldest first.
  class codec_scoreboard;
    codec_beat_t due_beats[$];
    logic        fmt_unsigned;
    logic [2:0]  remaining;
    logic [2:0]  pos;
    logic [31:0] acc;
    int          errors;

    function new();
      fmt_unsigned = 1'b0;
      remaining    = '0;
      pos          = '0;
      acc          = '0;
      errors       = 0;
    endfunction

    function void owe_byte(logic [7:0] b, logic last);
      codec_beat_t t;
      t.wire_byte = b;
      t.last      = last;
      t.value     = '0;
      t.ready     = 1'b0;
      due_beats.push_back(t);
    endfunction

    // a completed decode also returns the decoder to idle
    function void owe_value(logic [31:0] v);
      codec_beat_t t;
      t.wire_byte = '0;
      t.last      = 1'b0;
      t.value     = v;
      t.ready     = 1'b1;
      due_beats.push_back(t);
      remaining = '0;
      pos       = '0;
      acc       = '0;
    endfunction

    function void encode_signed(logic [31:0] n);
      logic [31:0] off_byte;
      logic [31:0] off_half;
      off_byte = n + 32'd126;
      off_half = n + 32'h0000_8000;
      if (off_byte <= 32'd253) begin
        owe_byte(n[7:0], 1'b1);
      end else if (off_half <= 32'h0000_FFFF) begin
        owe_byte(MARK_SHORT, 1'b0);
        owe_byte(n[7:0], 1'b0);
        owe_byte(n[15:8], 1'b1);
      end else begin
        owe_byte(MARK_LONG, 1'b0);
        owe_byte(n[7:0], 1'b0);
        owe_byte(n[15:8], 1'b0);
        owe_byte(n[23:16], 1'b0);
        owe_byte(n[31:24], 1'b1);
      end
    endfunction

    // 7-bit groups, low first; the fourth byte is a full 8 bits with no flag
    function void encode_unsigned(logic [31:0] n);
      logic [31:0] sh7;
      logic [31:0] sh14;
      sh7  = n >> 7;
      sh14 = n >> 14;
      if (n[31] || n >= 32'h0020_0000) begin
        owe_byte({1'b1, n[6:0]}, 1'b0);
        owe_byte({1'b1, n[13:7]}, 1'b0);
        owe_byte({1'b1, n[20:14]}, 1'b0);
        owe_byte(n[28:21], 1'b1);
      end else if (n < 32'd128) begin
        owe_byte(n[7:0], 1'b1);
      end else if (n < 32'h0000_4000) begin
        owe_byte({1'b1, n[6:0]}, 1'b0);
        owe_byte(sh7[7:0], 1'b1);
      end else begin
        owe_byte({1'b1, n[6:0]}, 1'b0);
        owe_byte({1'b1, n[13:7]}, 1'b0);
        owe_byte(sh14[7:0], 1'b1);
      end
    endfunction

    function void decode_signed(logic [7:0] b);
      if (remaining == 3'd0) begin
        if (b == MARK_SHORT) begin
          remaining = 3'd2;
          pos       = '0;
          acc       = '0;
        end else if (b == MARK_LONG) begin
          remaining = 3'd4;
          pos       = '0;
          acc       = '0;
        end else begin
          owe_value({{24{b[7]}}, b});
        end
      end else begin
        acc       = acc | ({24'd0, b} << (8 * pos[1:0]));
        pos       = pos + 3'd1;
        remaining = remaining - 3'd1;
        if (remaining == 3'd0) begin
          // short form: sign comes from the high byte
          if (pos == 3'd2 && acc[15]) acc[31:16] = 16'hFFFF;
          owe_value(acc);
        end
      end
    endfunction

    function void decode_unsigned(logic [7:0] b);
      logic [31:0] v;
      if (remaining == 3'd0) begin
        if (!b[7]) begin
          owe_value({24'd0, b});
        end else begin
          acc       = {25'd0, b[6:0]};
          pos       = 3'd1;
          remaining = 3'd1;
        end
      end else if (pos >= 3'd3) begin
        // fourth byte always closes; bit 28 is the sign
        v = acc | ({24'd0, b} << 21);
        if (v[28]) v[31:29] = 3'b111;
        owe_value(v);
      end else begin
        acc = acc | ({25'd0, b[6:0]} << (7 * pos));
        if (!b[7]) owe_value(acc);
        else pos = pos + 3'd1;
      end
    endfunction

    function void note_item(logic [1:0] op, logic [31:0] val, logic [7:0] b);
      case (op)
        OP_ENC_S: encode_signed(val);
        OP_ENC_U: encode_unsigned(val);
        default: begin
          // operation picks the format only on the first byte of a value
          if (remaining == 3'd0) fmt_unsigned = (op == OP_DEC_U);
          if (fmt_unsigned) decode_unsigned(b);
          else decode_signed(b);
        end
      endcase
    endfunction

    function void check_beat(logic [39:0] data, logic last, logic user);
      codec_beat_t want;
      if (due_beats.size() == 0) begin
        $display("%0t: beat with none due: byte %h last %b value %h ready %b",
                 $time, data[7:0], last, data[39:8], user);
        errors++;
        return;
      end
      want = due_beats.pop_front();
      if (data[7:0] !== want.wire_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.wire_byte, data[7:0]);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_byte expected %b actual %b", $time, want.last, last);
        errors++;
      end
      if (data[39:8] !== want.value) begin
        $display("%0t: decoded_value expected %h actual %h", $time, want.value, data[39:8]);
        errors++;
      end
      if (user !== want.ready) begin
        $display("%0t: value_ready expected %b actual %b", $time, want.ready, user);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]     s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  codec_scoreboard sb = new();
  int              items_sent = 0;
  int              sender_idle_pct = 21;
  int              receiver_idle_pct = 78;

  compact_integer_codec_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: check the beat taken at this edge, then roll the next stall
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // a beat is handed over at the first edge where tready is seen high
  task automatic send_item(input logic [1:0] op, input logic [31:0] val,
                           input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, val};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(op, val, b);
    items_sent++;
  endtask

  task automatic send_enc(input logic [1:0] op, input logic [31:0] val);
    send_item(op, val, 8'($urandom_range(255)));
  endtask

  task automatic send_dec(input logic [1:0] op, input logic [7:0] b);
    send_item(op, $urandom(), b);
  endtask

  // continuation byte: now and then an encode slips in, or the other decode
  // operation carries the byte (the value's format must win)
  task automatic dec_cont(input logic [1:0] op, input logic [7:0] b);
    if ($urandom_range(9) == 0) send_enc(2'($urandom_range(1)), $urandom());
    if ($urandom_range(9) == 0) send_dec(op == OP_DEC_U ? OP_DEC_S : OP_DEC_U, b);
    else send_dec(op, b);
  endtask

  // values spread over every encoded length
  function automatic logic [31:0] random_value();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(5))
      0: return 32'($urandom_range(253)) - 32'd126;
      1: return {{16{r[15]}}, r[15:0]};
      2: return {11'd0, r[20:0]};
      3: return {{3{r[28]}}, r[28:0]};
      4: begin
        case ($urandom_range(7))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return -32'sd127;
          3: return 32'd128;
          4: return -32'sd32769;
          5: return 32'd32767;
          6: return 32'h001F_FFFF;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return r;
    endcase
  endfunction

  initial begin
    int         pick;
    int         len;
    logic [7:0] b;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // signed encode at the edges of each length
    send_enc(OP_ENC_S, -32'sd126);
    send_enc(OP_ENC_S, 32'd127);
    send_enc(OP_ENC_S, -32'sd127);
    send_enc(OP_ENC_S, -32'sd32768);
    send_enc(OP_ENC_S, 32'd32768);
    send_enc(OP_ENC_S, 32'h8000_0000);
    // unsigned encode: group boundaries, bit 28 and a negative value
    send_enc(OP_ENC_U, 32'd127);
    send_enc(OP_ENC_U, 32'd128);
    send_enc(OP_ENC_U, 32'h0000_4000);
    send_enc(OP_ENC_U, 32'h001F_FFFF);
    send_enc(OP_ENC_U, 32'h1000_0000);
    send_enc(OP_ENC_U, 32'hFFFF_FFFF);
    // short marker, high byte negative
    send_dec(OP_DEC_S, MARK_SHORT);
    send_dec(OP_DEC_S, 8'h00);
    send_dec(OP_DEC_S, 8'h80);
    // long marker, carried on by the other decode op and broken by an encode
    send_dec(OP_DEC_S, MARK_LONG);
    send_dec(OP_DEC_U, 8'h78);
    send_enc(OP_ENC_U, 32'd300);
    send_dec(OP_DEC_S, 8'h56);
    send_dec(OP_DEC_S, 8'h34);
    send_dec(OP_DEC_S, 8'h12);
    // unsigned wrap through bit 28, a signed op in the middle
    send_dec(OP_DEC_U, 8'hFF);
    send_dec(OP_DEC_U, 8'hFF);
    send_dec(OP_DEC_S, 8'hFF);
    send_dec(OP_DEC_U, 8'hFF);
    // one-byte signed negative
    send_dec(OP_DEC_S, 8'hFF);

    while (items_sent < 180) begin
      // three idling phases: receiver slow, sender slow, then full rate
      if (items_sent < 60) begin
        sender_idle_pct   <= 21;
        receiver_idle_pct <= 78;
      end else if (items_sent < 120) begin
        sender_idle_pct   <= 78;
        receiver_idle_pct <= 21;
      end else begin
        sender_idle_pct   <= 0;
        receiver_idle_pct <= 0;
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_enc(2'($urandom_range(1)), random_value());
      end else if (pick < 60) begin
        case ($urandom_range(2))
          0: begin
            send_dec(OP_DEC_S, MARK_SHORT);
            repeat (2) dec_cont(OP_DEC_S, 8'($urandom_range(255)));
          end
          1: begin
            send_dec(OP_DEC_S, MARK_LONG);
            repeat (4) dec_cont(OP_DEC_S, 8'($urandom_range(255)));
          end
          default: send_dec(OP_DEC_S, 8'($urandom_range(255)));
        endcase
      end else if (pick < 85) begin
        // well-formed unsigned value of one to four bytes
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          b = 8'($urandom_range(255));
          if (k < len - 1) b[7] = 1'b1;
          else if (len < 4) b[7] = 1'b0;
          if (k == 0) send_dec(OP_DEC_U, b);
          else dec_cont(OP_DEC_U, b);
        end
      end else begin
        // noise: loose decode bytes of either format
        send_dec($urandom_range(1) ? OP_DEC_U : OP_DEC_S, 8'($urandom_range(255)));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.due_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
